// ===== design/tms_pkg.sv =====
// ----------------------------------------------------------------------------
// tms_pkg
// Shared types and codes for the two-task message scheduler: payload
// structs, operation codes, task numbers and the controller state type.
// ----------------------------------------------------------------------------
package tms_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 64;

   localparam logic [2:0] MODE_POST   = 3'd0;
   localparam logic [2:0] MODE_PEND   = 3'd1;
   localparam logic [2:0] MODE_DELAY  = 3'd2;
   localparam logic [2:0] MODE_TICK   = 3'd3;
   localparam logic [2:0] MODE_RESUME = 3'd4;

   localparam logic TASK_LOGIC = 1'b0;
   localparam logic TASK_MENU  = 1'b1;

   typedef struct packed {
      logic [2:0]  mode;
      logic [31:0] message;
      logic [30:0] delay_ticks;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [31:0] message_out;
      logic        blocked;
      logic        switch_request;
      logic        running_task;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load_item;
      logic commit;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_held;
   } dp_status_type;

endpackage

// ===== design/tms_ctrl.sv =====
// ----------------------------------------------------------------------------
// tms_ctrl
// Controller: takes one word into the datapath, then commits it once the
// result register has room.
// ----------------------------------------------------------------------------
module tms_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tms_pkg::dp_status_type status,
   output tms_pkg::dp_cmd_type    cmd
);
   import tms_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!status.out_held) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall     = 1'b1;
      cmd.load_item = 1'b0;
      cmd.commit    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall     = reset;
            cmd.load_item = req_valid && !reset;
         end
         ST_EXEC: begin
            cmd.commit = !status.out_held;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ===== design/tms_datapath.sv =====
// ----------------------------------------------------------------------------
// tms_datapath
// Datapath: message ring, mailbox, delay counter, running task and the
// result register.
// ----------------------------------------------------------------------------
module tms_datapath #(
   parameter int QUEUE_DEPTH = tms_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tms_pkg::req_type       req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tms_pkg::rsp_type       rsp_payload,
   input  tms_pkg::dp_cmd_type    cmd,
   output tms_pkg::dp_status_type status
);
   import tms_pkg::*;

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   logic [31:0]      mem_ff [QUEUE_DEPTH];
   logic [31:0]      rd_data_ff;
   logic             wr_en;

   req_type          item_ff;
   logic [IDX_W-1:0] read_index_ff, read_index_in;
   logic [IDX_W-1:0] write_index_ff, write_index_in;
   logic [CNT_W-1:0] fill_count_ff, fill_count_in;
   logic [31:0]      mailbox_ff, mailbox_in;
   logic [30:0]      delay_ff, delay_in;
   logic             task_ff, task_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   // The head entry is read every cycle; an item always waits in the item
   // register before its commit, so the read sees the last commit.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[write_index_ff] <= item_ff.message;
      end
      rd_data_ff <= mem_ff[read_index_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_payload;
      end
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_index_ff  <= '0;
         write_index_ff <= '0;
         fill_count_ff  <= '0;
         mailbox_ff     <= '0;
         delay_ff       <= '0;
         task_ff        <= TASK_LOGIC;
         rsp_valid_ff   <= 1'b0;
      end else begin
         read_index_ff  <= read_index_in;
         write_index_ff <= write_index_in;
         fill_count_ff  <= fill_count_in;
         mailbox_ff     <= mailbox_in;
         delay_ff       <= delay_in;
         task_ff        <= task_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_comb begin
      read_index_in  = read_index_ff;
      write_index_in = write_index_ff;
      fill_count_in  = fill_count_ff;
      mailbox_in     = mailbox_ff;
      delay_in       = delay_ff;
      task_in        = task_ff;
      wr_en          = 1'b0;
      rsp_in.accepted       = 1'b1;
      rsp_in.message_out    = '0;
      rsp_in.blocked        = 1'b0;
      rsp_in.switch_request = 1'b0;
      if (cmd.commit) begin
         case (item_ff.mode)
            MODE_POST: begin
               if (task_ff == TASK_MENU && mailbox_ff == '0) begin
                  delay_in   = '0;
                  mailbox_in = item_ff.message;
                  task_in    = TASK_LOGIC;
                  rsp_in.switch_request = 1'b1;
               end else if (fill_count_ff == FULL_CNT) begin
                  rsp_in.accepted = 1'b0;
               end else begin
                  wr_en          = 1'b1;
                  write_index_in = (write_index_ff == LAST_IDX) ? '0
                                 : write_index_ff + IDX_W'(1);
                  fill_count_in  = fill_count_ff + CNT_W'(1);
               end
            end
            MODE_PEND: begin
               if (mailbox_ff != '0) begin
                  rsp_in.message_out = mailbox_ff;
                  mailbox_in         = '0;
               end else if (fill_count_ff != '0) begin
                  rsp_in.message_out = rd_data_ff;
                  read_index_in      = (read_index_ff == LAST_IDX) ? '0
                                     : read_index_ff + IDX_W'(1);
                  fill_count_in      = fill_count_ff - CNT_W'(1);
               end else begin
                  delay_in       = '0;
                  rsp_in.blocked = 1'b1;
                  task_in        = TASK_MENU;
                  rsp_in.switch_request = (task_ff != TASK_MENU);
               end
            end
            MODE_DELAY: begin
               if (item_ff.delay_ticks != '0) begin
                  delay_in = item_ff.delay_ticks;
                  task_in  = TASK_MENU;
                  rsp_in.switch_request = (task_ff != TASK_MENU);
               end
            end
            MODE_TICK: begin
               if (delay_ff != '0) begin
                  delay_in = delay_ff - 31'd1;
                  // wake the logic task on the last tick
                  if (delay_ff == 31'd1) begin
                     task_in = TASK_LOGIC;
                     rsp_in.switch_request = (task_ff != TASK_LOGIC);
                  end
               end
            end
            MODE_RESUME: begin
               rsp_in.message_out = mailbox_ff;
               mailbox_in         = '0;
            end
            default: begin
            end
         endcase
      end
      rsp_in.running_task = task_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign status.out_held = rsp_valid_ff && rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_payload     = rsp_ff;

endmodule

// ===== design/two_task_message_scheduler.sv =====
// ----------------------------------------------------------------------------
// two_task_message_scheduler
// Kernel-assist block for a logic task and a menu task: message ring,
// mailbox, delay countdown and running task, one operation per word.
// ----------------------------------------------------------------------------
//   channel   ports                              direction
//   request   req_valid, req_stall, req_payload  in  (mode, message, ticks)
//   response  rsp_valid, rsp_stall, rsp_payload  out (one word per request)
//
// Each request waits in the item register while the ring's head entry is
// read from memory, then commits. A new request is taken only once the
// previous one has committed, so a held response delays the next request.
// A held response stalls the commit, not the request capture.
// Reset is synchronous and needs no clearing pass; the ring is not cleared.
module two_task_message_scheduler #(
   parameter int QUEUE_DEPTH = tms_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tms_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tms_pkg::rsp_type rsp_payload
);
   import tms_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   tms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tms_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// ===== design/tms_checker.sv =====
// ----------------------------------------------------------------------------
// tms_checker
// Port-level checks for the two-task message scheduler.
// ----------------------------------------------------------------------------
module tms_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input tms_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input tms_pkg::rsp_type rsp_payload
);
   import tms_pkg::*;

   // a held request word does not change
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload))
      else $error("request word changed while stalled");

   // a held response word does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response word changed while stalled");

   // a request occupies the block for the following cycle
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken on consecutive cycles");

   // a blocked pend always leaves the menu task running, returns no message and is accepted
   a_blocked_menu: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.blocked |->
         rsp_payload.running_task == TASK_MENU && rsp_payload.message_out == '0
         && rsp_payload.accepted)
      else $error("blocked response inconsistent");

   // a rejected post changes nothing
   a_reject_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.accepted |->
         !rsp_payload.switch_request && !rsp_payload.blocked
         && rsp_payload.message_out == '0)
      else $error("rejected post reported side effects");

endmodule

bind two_task_message_scheduler tms_checker u_tms_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);
